[rtl/core/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumRounds = 64;

  typedef logic [WordW-1:0] word_t;

  // Request from the front end to the compression engine.
  typedef struct packed {
    logic wr_en;
    logic [3:0] wr_addr;
    word_t wr_data;
    logic start;
  } sched_req_t;

  function automatic word_t ror32(input word_t v, input int unsigned amt);
    ror32 = (v >> amt) | (v << (WordW - amt));
  endfunction

  function automatic word_t round_const(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_const = k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    init_hash = h;
  endfunction

endpackage

[rtl/core/sha_engine.sv]
`timescale 1ns / 1ps
module sha_engine
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sched_req_t req,
  input  logic       chain_reset,
  input  logic [2:0] chain_idx,
  output word_t      chain_word,
  output logic       busy
);

  // Message schedule lives in a 16-entry memory, rewritten in place during rounds.
  word_t sched_mem [16];
  word_t chain_r [8];
  word_t va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;

  typedef enum logic [2:0] {
    E_IDLE, E_RD15, E_RD2, E_RD7, E_RD16, E_ROUND, E_FOLD
  } eng_state_t;

  eng_state_t state_r;
  logic [5:0] rnd_r;
  logic [3:0] rd_addr;
  word_t rd_data_r;
  word_t x15_r, x2_r, x7_r;
  logic sw_en;
  logic [3:0] sw_addr;
  word_t sw_data;
  word_t wv, s0, s1, big0, big1, ch, maj, t1, t2;
  logic [3:0] slot;

  assign slot = rnd_r[3:0];
  assign busy = (state_r != E_IDLE);
  assign chain_word = chain_r[chain_idx];

  // Per round: read W[r+1], W[r+14], W[r+9], W[r] then do the round; rounds 0..15 read only W[r].
  always_comb begin
    case (state_r)
      E_RD15: rd_addr = slot + 4'd1;
      E_RD2: rd_addr = slot + 4'd14;
      E_RD7: rd_addr = slot + 4'd9;
      default: rd_addr = slot;
    endcase
  end

  always_comb begin
    s0 = ror32(x15_r, 7) ^ ror32(x15_r, 18) ^ (x15_r >> 3);
    s1 = ror32(x2_r, 17) ^ ror32(x2_r, 19) ^ (x2_r >> 10);
    wv = (rnd_r >= 6'd16) ? rd_data_r + s0 + x7_r + s1 : rd_data_r;
    big1 = ror32(ve_r, 6) ^ ror32(ve_r, 11) ^ ror32(ve_r, 25);
    ch = (ve_r & vf_r) ^ (~ve_r & vg_r);
    t1 = vh_r + big1 + ch + round_const(rnd_r) + wv;
    big0 = ror32(va_r, 2) ^ ror32(va_r, 13) ^ ror32(va_r, 22);
    maj = (va_r & vb_r) ^ (va_r & vc_r) ^ (vb_r & vc_r);
    t2 = big0 + maj;
    sw_en = req.wr_en;
    sw_addr = req.wr_addr;
    sw_data = req.wr_data;
    if (state_r == E_ROUND && rnd_r >= 6'd16) begin
      sw_en = 1'b1;
      sw_addr = slot;
      sw_data = wv;
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      sched_mem[sw_addr] <= sw_data;
    end
    rd_data_r <= sched_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      rnd_r <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
      {va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r} <= '0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (chain_reset) begin
            for (int i = 0; i < 8; i++) chain_r[i] <= init_hash(3'(i));
          end
          if (req.start) begin
            {va_r, vb_r, vc_r, vd_r} <= {chain_r[0], chain_r[1], chain_r[2], chain_r[3]};
            {ve_r, vf_r, vg_r, vh_r} <= {chain_r[4], chain_r[5], chain_r[6], chain_r[7]};
            rnd_r <= '0;
            state_r <= E_RD16;
          end
        end
        E_RD15: state_r <= E_RD2;
        E_RD2: begin
          x15_r <= rd_data_r;
          state_r <= E_RD7;
        end
        E_RD7: begin
          x2_r <= rd_data_r;
          state_r <= E_RD16;
        end
        E_RD16: begin
          if (rnd_r >= 6'd16) x7_r <= rd_data_r;
          state_r <= E_ROUND;
        end
        E_ROUND: begin
          {vh_r, vg_r, vf_r, ve_r} <= {vg_r, vf_r, ve_r, vd_r + t1};
          {vd_r, vc_r, vb_r, va_r} <= {vc_r, vb_r, va_r, t1 + t2};
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(NumRounds - 1)) state_r <= E_FOLD;
          else if (rnd_r >= 6'd15) state_r <= E_RD15;
          else state_r <= E_RD16;
        end
        E_FOLD: begin
          chain_r[0] <= chain_r[0] + va_r; chain_r[1] <= chain_r[1] + vb_r;
          chain_r[2] <= chain_r[2] + vc_r; chain_r[3] <= chain_r[3] + vd_r;
          chain_r[4] <= chain_r[4] + ve_r; chain_r[5] <= chain_r[5] + vf_r;
          chain_r[6] <= chain_r[6] + vg_r; chain_r[7] <= chain_r[7] + vh_r;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// SHA-256 hasher for a stream of big-endian 32-bit message words.
// Input channel: in_message_word, in_valid_bytes (0..4, below 4 only with
// in_last_word) and in_last_word, under in_valid / in_ready.
// Output channel: eight digest words per message, index 0..7, with
// out_digest_last on the eighth, under out_valid / out_ready.
// A word that does not fill a block is written into the schedule memory
// and leaves the input ready. The sixteenth word of a block starts the
// compression: 64 rounds from a 16-entry schedule memory with a registered
// read port, rounds 0..15 reading W[r] and rounds 16..63 W[r+1], W[r+14],
// W[r+9] and W[r], then a fold into the chaining value; meanwhile no
// request is taken. A last word adds one or two padding blocks; padding
// words are written one per cycle while no block is compressing. The
// digest then leaves one word per cycle while out_ready is high; a stall
// holds the current word and the next message waits until all eight are
// taken. After reset the chaining value holds the initial hash values and
// the bit count and word position are zero; the block is ready at once.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_digest_index,
  output logic        out_digest_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LENHI, S_LENLO, S_WAIT, S_OUT
  } top_state_t;

  top_state_t state_r;
  logic [3:0] slot_r;
  logic [63:0] bits_r, bits_nxt;
  logic [2:0] oidx_r;
  logic pad_final_r;
  sched_req_t req;
  logic chain_reset;
  logic busy;
  word_t chain_word;
  word_t masked, padded;
  logic [2:0] nv;
  logic in_fire, out_fire, pushing;

  assign nv = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign in_ready = (state_r == S_IDLE) && !busy;
  assign in_fire = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_fire = out_valid && out_ready;
  assign out_digest_word = chain_word;
  assign out_digest_index = oidx_r;
  assign out_digest_last = (oidx_r == 3'd7);
  assign bits_nxt = bits_r + {58'd0, nv, 3'd0};

  always_comb begin
    case (nv)
      3'd0: begin masked = '0; padded = 32'h80000000; end
      3'd1: begin masked = {in_message_word[31:24], 24'd0};
                  padded = masked | 32'h00800000; end
      3'd2: begin masked = {in_message_word[31:16], 16'd0};
                  padded = masked | 32'h00008000; end
      3'd3: begin masked = {in_message_word[31:8], 8'd0};
                  padded = masked | 32'h00000080; end
      default: begin masked = in_message_word; padded = in_message_word; end
    endcase
  end

  always_comb begin
    req = '0;
    pushing = 1'b0;
    if (!busy) begin
      case (state_r)
        S_IDLE: if (in_fire) begin
          pushing = 1'b1;
          req.wr_data = (in_last_word && nv != 3'd4) ? padded : masked;
        end
        S_PAD: begin
          pushing = 1'b1;
          req.wr_data = pad_final_r ? 32'h80000000 : 32'h0;
        end
        S_LENHI: begin pushing = 1'b1; req.wr_data = bits_r[63:32]; end
        S_LENLO: begin pushing = 1'b1; req.wr_data = bits_r[31:0]; end
        default: pushing = 1'b0;
      endcase
    end
    req.wr_en = pushing;
    req.wr_addr = slot_r;
    req.start = pushing && (slot_r == 4'd15);
  end

  assign chain_reset = (state_r == S_OUT) && out_fire && out_digest_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r <= '0;
      bits_r <= '0;
      oidx_r <= '0;
      pad_final_r <= 1'b0;
    end else begin
      if (pushing) slot_r <= slot_r + 4'd1;
      case (state_r)
        S_IDLE: if (in_fire) begin
          bits_r <= bits_nxt;
          if (in_last_word) begin
            // A full last word needs a separate 0x80 word next.
            pad_final_r <= (nv == 3'd4);
            state_r <= (nv == 3'd4 || slot_r + 4'd1 != 4'd14) ? S_PAD : S_LENHI;
          end
        end
        S_PAD: if (!busy) begin
          pad_final_r <= 1'b0;
          if (slot_r + 4'd1 == 4'd14) state_r <= S_LENHI;
        end
        S_LENHI: if (!busy) state_r <= S_LENLO;
        S_LENLO: if (!busy) state_r <= S_WAIT;
        S_WAIT: if (!busy) begin
          oidx_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_fire) begin
          oidx_r <= oidx_r + 3'd1;
          if (out_digest_last) begin
            bits_r <= '0;
            slot_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  sha_engine u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .req(req),
    .chain_reset(chain_reset),
    .chain_idx(oidx_r),
    .chain_word(chain_word),
    .busy(busy)
  );

  a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during digest output");
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("digest shown while compressing");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_digest_last) |=> (out_valid && out_digest_index == $past(oidx_r) + 3'd1))
    else $error("digest index did not advance");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_digest_last) |=> (slot_r == 4'd0 && bits_r == 64'd0))
    else $error("state not cleared after digest");

endmodule

[tb/sv/tb_sha256_stream_hasher.sv]
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } msg_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_message_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_digest_index;
  logic        out_digest_last;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_message_word(in_message_word), .in_valid_bytes(in_valid_bytes),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_digest_index(out_digest_index),
    .out_digest_last(out_digest_last)
  );

  // Hash state of the predictor.
  logic [31:0] chain_h[8];
  logic [31:0] sched_w[16];
  logic [63:0] msg_bits;
  int unsigned slot;

  msg_req_t    pending_reqs[$];
  digest_t     expected_digest[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          timed_out;

  localparam logic [31:0] IV0 = 32'h6a09e667, IV1 = 32'hbb67ae85,
    IV2 = 32'h3c6ef372, IV3 = 32'ha54ff53a, IV4 = 32'h510e527f,
    IV5 = 32'h9b05688c, IV6 = 32'h1f83d9ab, IV7 = 32'h5be0cd19;

  localparam logic [31:0] K_TAB[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic reset_chain();
    chain_h = '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
    msg_bits = '0;
    slot = 0;
  endtask

  task automatic compress_block();
    logic [31:0] v[8];
    logic [31:0] s0, s1, t1, t2;
    for (int q = 0; q < 8; q++) v[q] = chain_h[q];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        s0 = sched_w[(r + 1) % 16];
        s1 = sched_w[(r + 14) % 16];
        s0 = rotr(s0, 7) ^ rotr(s0, 18) ^ (s0 >> 3);
        s1 = rotr(s1, 17) ^ rotr(s1, 19) ^ (s1 >> 10);
        sched_w[r % 16] = sched_w[r % 16] + s0 + sched_w[(r + 9) % 16] + s1;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + sched_w[r % 16];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int q = 0; q < 8; q++) chain_h[q] += v[q];
  endtask

  task automatic push_block_word(input logic [31:0] w);
    sched_w[slot] = w;
    slot = (slot + 1) % 16;
    if (slot == 0) compress_block();
  endtask

  task automatic hash_message_word(input msg_req_t req);
    logic [31:0] w;
    int unsigned nb;
    digest_t d;
    nb = (req.nbytes > 4) ? 4 : req.nbytes;
    w = req.word;
    if (nb < 4) w = (nb == 0) ? 32'h0 : (w & (32'hffffffff << (32 - 8 * nb)));
    msg_bits += 64'(8 * nb);
    if (!req.last) begin
      push_block_word(w);
      return;
    end
    if (nb == 4) begin
      push_block_word(w);
      push_block_word(32'h80000000);
    end else begin
      push_block_word(w | (32'h80 << (24 - 8 * nb)));
    end
    if (slot == 15) push_block_word(32'h0);
    while (slot < 14) push_block_word(32'h0);
    push_block_word(msg_bits[63:32]);
    push_block_word(msg_bits[31:0]);
    for (int q = 0; q < 8; q++) begin
      d.word = chain_h[q];
      d.index = 3'(q);
      d.last = (q == 7);
      expected_digest.push_back(d);
    end
    reset_chain();
  endtask

  function automatic msg_req_t make_req(input logic [31:0] w, input int nb,
                                        input bit last);
    msg_req_t r;
    r.word = w;
    r.nbytes = 3'(nb);
    r.last = last;
    return r;
  endfunction

  // Random message: mostly whole words, with occasional noise words that carry
  // a random count 0..7 without last; the last word carries 0..4 or 5..7.
  task automatic queue_message(input int unsigned nwords);
    int nb;
    for (int unsigned i = 0; i + 1 < nwords; i++) begin
      nb = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 7) : 4;
      pending_reqs.push_back(make_req($urandom, nb, 1'b0));
    end
    nb = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    pending_reqs.push_back(make_req($urandom, nb, 1'b1));
  endtask

  function automatic int unsigned pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(1, 4);
    if (sel < 7) return $urandom_range(13, 18);
    return $urandom_range(5, 32);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready) hash_message_word(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_message_word <= pending_reqs[0].word;
        in_valid_bytes <= pending_reqs[0].nbytes;
        in_last_word <= pending_reqs[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor, receiver stalls and watchdog.
  always @(posedge clk) begin
    digest_t exp_d;
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_digest.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected digest word %h index %0d", out_digest_word,
                     out_digest_index);
        end else begin
          exp_d = expected_digest.pop_front();
          if (out_digest_word !== exp_d.word || out_digest_index !== exp_d.index ||
              out_digest_last !== exp_d.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       exp_d.word, exp_d.index, exp_d.last, out_digest_word,
                       out_digest_index, out_digest_last);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_message_word = '0;
    in_valid_bytes = '0;
    in_last_word = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    timed_out = 1'b0;
    for (int i = 0; i < 16; i++) sched_w[i] = '0;
    reset_chain();

    // Directed messages: empty, each short length, full word with last,
    // saturated count, short word inside a message, a 55 byte message.
    pending_reqs.push_back(make_req(32'hffffffff, 0, 1'b1));
    for (int nb = 1; nb <= 4; nb++)
      pending_reqs.push_back(make_req(32'h61626364, nb, 1'b1));
    pending_reqs.push_back(make_req(32'hffffffff, 7, 1'b1));
    pending_reqs.push_back(make_req(32'h00000000, 4, 1'b1));
    pending_reqs.push_back(make_req(32'hdeadbeef, 2, 1'b0));
    pending_reqs.push_back(make_req(32'h12345678, 5, 1'b1));
    for (int i = 0; i < 13; i++)
      pending_reqs.push_back(make_req(32'hffffffff, 4, 1'b0));
    pending_reqs.push_back(make_req(32'h80808080, 3, 1'b1));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 33 : 0;
      for (int m = 0; m < 5; m++) queue_message(pick_len());
      if (ph == 2) begin
        // Long receiver hold-off while several short messages are offered.
        for (int m = 0; m < 4; m++) queue_message(1);
        hold_cycles = 3000;
      end
      wait (pending_reqs.size() == 0);
      wait (expected_digest.size() == 0);
    end
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_digest.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
